FILE: hw/rtl/sfd_pkg.sv
// Shared types and constants for the span fill block with ordered dither.
// No dependencies; imported by the span controller and the top level.
package sfd_pkg;

  // Number of dither levels and the level in force after reset
  localparam int unsigned LEVEL_COUNT = 17;
  localparam logic [4:0]  LEVEL_RESET = 5'd8;

  // Drawing operation carried in the mode field
  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_SET    = 2'd1,
    MODE_INVERT = 2'd2,
    MODE_UNUSED = 2'd3
  } span_mode_t;

  // Controller states
  typedef enum logic [1:0] {
    SFD_CLEAR,
    SFD_IDLE,
    SFD_READ,
    SFD_MODIFY
  } sfd_state_t;

  // Four pattern bytes per level, row phase 0 in the lowest byte
  localparam logic [31:0] DITHER_ROWS [LEVEL_COUNT] = '{
    32'h00_00_00_00,
    32'h00_00_00_88,
    32'h00_22_00_88,
    32'h00_aa_00_88,
    32'h00_aa_00_aa,
    32'h00_aa_44_aa,
    32'h11_aa_44_aa,
    32'h55_aa_44_aa,
    32'h55_aa_55_aa,
    32'h55_aa_dd_aa,
    32'h77_aa_dd_aa,
    32'hff_aa_dd_aa,
    32'hff_aa_ff_aa,
    32'hff_aa_ff_bb,
    32'hff_ee_ff_bb,
    32'hff_ff_ff_bb,
    32'hff_ff_ff_ff
  };

  // Pattern byte for a level and a row phase (row mod 4)
  function automatic logic [7:0] dither_pattern(input logic [4:0] level,
                                                input logic [1:0] phase);
    logic [31:0] word;
    word = DITHER_ROWS[level];
    return word[{phase, 3'b000} +: 8];
  endfunction

endpackage

FILE: hw/rtl/sfd_frame_ram.sv
// Frame store: single clock memory, one write and one read port.
// Read data is registered and holds until the next read is issued.
module sfd_frame_ram #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = 10
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/sfd_span_ctrl.sv
// Span sequencer: clears the frame store after reset, then walks each span
// byte by byte with read-modify-write. Uses sfd_pkg and sfd_frame_ram.
module sfd_span_ctrl #(
  parameter int unsigned WIDTH_PIXELS = 128,
  parameter int unsigned HEIGHT_ROWS  = 64
) (
  input  logic       clk,
  input  logic       rst,
  // span transaction
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [6:0] x_start,
  input  logic [6:0] x_end,
  input  logic [5:0] row,
  input  logic [1:0] mode,
  input  logic       dithered,
  input  logic [4:0] dither_level,
  // result transaction
  output logic       out_valid,
  input  logic       out_ready,
  output logic [9:0] byte_address,
  output logic [7:0] byte_value,
  output logic       last
);
  import sfd_pkg::*;

  localparam int unsigned ROW_BYTES   = (WIDTH_PIXELS + 7) / 8;
  localparam int unsigned STORE_BYTES = ROW_BYTES * HEIGHT_ROWS;
  localparam int unsigned AW  = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int unsigned FAW = (AW > 10) ? AW : 10;
  localparam int unsigned XMAX_I = (WIDTH_PIXELS - 1 > 127) ? 127 : WIDTH_PIXELS - 1;
  localparam logic [6:0]     XMAX      = 7'(XMAX_I);
  localparam logic [FAW-1:0] ROW_BYTES_W = FAW'(ROW_BYTES);
  localparam logic [AW-1:0]  LAST_ENTRY  = AW'(STORE_BYTES - 1);

  sfd_state_t state, state_next;

  // Span registers
  logic [3:0]     col;
  logic [3:0]     col_first;
  logic [3:0]     col_last;
  logic [7:0]     smask;
  logic [7:0]     emask;
  logic [7:0]     pat;
  span_mode_t     op;
  logic [FAW-1:0] base;
  logic [AW-1:0]  clr_cnt;

  // Setup terms from the incoming transaction
  logic [6:0]     xs_ord, xe_ord, xs_sat, xe_sat;
  logic           row_ok, span_ok, accept;
  logic [FAW-1:0] base_in;

  // Per-byte terms
  logic [FAW-1:0] cur_addr, nxt_addr;
  logic [7:0]     rd_data, mask, new_val;
  logic           is_first, is_last, at_edge, out_free, fire;

  // RAM port
  logic           wr_en, rd_en;
  logic [AW-1:0]  wr_addr, rd_addr;
  logic [7:0]     wr_data;

  sfd_frame_ram #(
    .DEPTH  (STORE_BYTES),
    .ADDR_W (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Order and saturate the endpoints, check the row and the mode
  always_comb begin
    xs_ord  = (x_end < x_start) ? x_end : x_start;
    xe_ord  = (x_end < x_start) ? x_start : x_end;
    xs_sat  = (xs_ord > XMAX) ? XMAX : xs_ord;
    xe_sat  = (xe_ord > XMAX) ? XMAX : xe_ord;
    row_ok  = {5'd0, row} < 11'(HEIGHT_ROWS);
    span_ok = row_ok && (span_mode_t'(mode) != MODE_UNUSED);
    base_in = FAW'(row) * ROW_BYTES_W;
  end

  // Byte address and new contents
  always_comb begin
    cur_addr = base + FAW'(col);
    nxt_addr = cur_addr + FAW'(1);
    is_first = (col == col_first);
    is_last  = (col == col_last);
    at_edge  = is_first || is_last;
    mask     = pat;
    if (is_first) begin
      mask = mask & smask;
    end
    if (is_last) begin
      mask = mask & emask;
    end
    case (op)
      MODE_SET:    new_val = at_edge ? (rd_data | mask) : pat;
      MODE_CLEAR:  new_val = at_edge ? (rd_data & ~mask) : ~pat;
      MODE_INVERT: new_val = rd_data ^ mask;
      default:     new_val = rd_data;
    endcase
  end

  // Next state and strobes
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_free   = !out_valid || out_ready;
    fire       = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = cur_addr[AW-1:0];
    wr_data    = new_val;
    rd_en      = 1'b0;
    rd_addr    = cur_addr[AW-1:0];
    case (state)
      SFD_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt;
        wr_data = 8'h00;
        if (clr_cnt == LAST_ENTRY) begin
          state_next = SFD_IDLE;
        end
      end
      SFD_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && span_ok) begin
          state_next = SFD_READ;
        end
      end
      SFD_READ: begin
        rd_en      = 1'b1;
        state_next = SFD_MODIFY;
      end
      SFD_MODIFY: begin
        if (out_free) begin
          fire  = 1'b1;
          wr_en = 1'b1;
          if (is_last) begin
            state_next = SFD_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = nxt_addr[AW-1:0];
          end
        end
      end
      default: state_next = SFD_IDLE;
    endcase
  end

  assign accept = in_valid && in_ready;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SFD_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Clearing sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (state == SFD_CLEAR) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  // Latch span setup, advance the byte column
  always_ff @(posedge clk) begin
    if (accept) begin
      col       <= xs_sat[6:3];
      col_first <= xs_sat[6:3];
      col_last  <= xe_sat[6:3];
      smask     <= 8'hff >> xs_sat[2:0];
      emask     <= 8'hff << (3'd7 - xe_sat[2:0]);
      pat       <= dithered ? dither_pattern(dither_level, row[1:0]) : 8'hff;
      op        <= span_mode_t'(mode);
      base      <= base_in;
    end else if (fire) begin
      col <= col + 4'd1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      byte_address <= cur_addr[9:0];
      byte_value   <= new_val;
      last         <= is_last;
    end
  end

endmodule

FILE: hw/rtl/span_fill_with_dither.sv
// Top level of the span fill block: dither level register, stream unpacking
// and packing. Depends on sfd_pkg and sfd_span_ctrl.
//
// Usage: each transaction on the s_axis channel draws one horizontal span on
// one row of a 1-bit frame store (8 pixels per byte, leftmost pixel in bit 7).
// For every byte the span touches, one transaction leaves on m_axis with the
// byte address and its new contents, in ascending address order; tlast marks
// the final byte of the span. Spans on rows outside the frame, or with the
// unused mode, give no output. cfg_wr_en/cfg_wr_data set the dither level;
// values above 16 are ignored. Write the level only while the block is idle.
// Operation: after a span is accepted, its first byte is read, then each byte
// is one read-modify-write on the frame store memory, and the next byte's read
// overlaps the current byte's write. A new span can be accepted in the cycle
// after the previous one finishes; none is accepted while a span is in
// progress. Each result is registered into the output as its byte is written.
// While m_axis is stalled the sequencer holds its current byte.
// Reset: the level returns to 8 and the frame store is cleared by a sweep of
// one byte per cycle over ROW_BYTES * HEIGHT_ROWS bytes (1024 by default) with
// s_axis_tready low.
module span_fill_with_dither #(
  parameter int unsigned WIDTH_PIXELS = 128,
  parameter int unsigned HEIGHT_ROWS  = 64
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,   // dither_level
  // span input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // x_start[6:0], x_end[13:7], row[19:14],
                                     // mode[21:20], dithered[22], zero pad
  // byte output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // byte_address[9:0], byte_value[17:10],
                                     // zero pad
  output logic        m_axis_tlast
);
  import sfd_pkg::*;

  logic [4:0] dither_level;
  logic [9:0] byte_address;
  logic [7:0] byte_value;

  // Dither level: drop writes outside the table
  always_ff @(posedge clk) begin
    if (rst) begin
      dither_level <= LEVEL_RESET;
    end else if (cfg_wr_en && ({1'b0, cfg_wr_data} < 6'(LEVEL_COUNT))) begin
      dither_level <= cfg_wr_data;
    end
  end

  sfd_span_ctrl #(
    .WIDTH_PIXELS (WIDTH_PIXELS),
    .HEIGHT_ROWS  (HEIGHT_ROWS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .x_start      (s_axis_tdata[6:0]),
    .x_end        (s_axis_tdata[13:7]),
    .row          (s_axis_tdata[19:14]),
    .mode         (s_axis_tdata[21:20]),
    .dithered     (s_axis_tdata[22]),
    .dither_level (dither_level),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .byte_address (byte_address),
    .byte_value   (byte_value),
    .last         (m_axis_tlast)
  );

  // Pack the result fields
  assign m_axis_tdata = {6'd0, byte_value, byte_address};

endmodule

FILE: bench/tb_span_fill_with_dither.sv
// Self-checking testbench for span_fill_with_dither: directed spans, then random spans
// under several dither levels, each checked against an in-bench framebuffer model.
// Depends on sfd_pkg and the span_fill_with_dither RTL.
`timescale 1ns / 100ps

module tb_span_fill_with_dither;
  import sfd_pkg::*;

  localparam int SETTLE_CYCLES = 24;   // longest span is 16 bytes
  localparam int HOLD_CYCLES   = 300;
  localparam int ROW_BYTES     = 16;
  localparam int NO_WRITE      = -1;
  localparam int NO_VALUE      = -1;
  localparam int PHASE_SPANS   = 39;

  // Pattern bytes, four per level, row phase 0 first
  localparam logic [0:67][7:0] DITHER_BYTES = {
    8'h00, 8'h00, 8'h00, 8'h00,  8'h88, 8'h00, 8'h00, 8'h00,
    8'h88, 8'h00, 8'h22, 8'h00,  8'h88, 8'h00, 8'haa, 8'h00,
    8'haa, 8'h00, 8'haa, 8'h00,  8'haa, 8'h44, 8'haa, 8'h00,
    8'haa, 8'h44, 8'haa, 8'h11,  8'haa, 8'h44, 8'haa, 8'h55,
    8'haa, 8'h55, 8'haa, 8'h55,  8'haa, 8'hdd, 8'haa, 8'h55,
    8'haa, 8'hdd, 8'haa, 8'h77,  8'haa, 8'hdd, 8'haa, 8'hff,
    8'haa, 8'hff, 8'haa, 8'hff,  8'hbb, 8'hff, 8'haa, 8'hff,
    8'hbb, 8'hff, 8'hee, 8'hff,  8'hbb, 8'hff, 8'hff, 8'hff,
    8'hff, 8'hff, 8'hff, 8'hff
  };

  typedef struct {
    logic [6:0] xs;
    logic [6:0] xe;
    logic [5:0] row;
    span_mode_t mode;
    logic       dith;
  } span_t;

  typedef struct {
    logic [9:0] addr;
    logic [7:0] value;
    logic       last;
  } byte_write_t;

  // Directed plan: level to write first, span fields, and byte value where obvious
  typedef struct packed {
    int lvl;
    int xs;
    int xe;
    int row;
    int mode;
    int dith;
    int val;
  } plan_row_t;

  localparam int PLAN_ROWS = 21;
  localparam plan_row_t PLAN [0:PLAN_ROWS-1] = '{
    '{NO_WRITE,   0, 127,  0, MODE_SET,    0, 'hff},
    '{NO_WRITE, 127,   0,  0, MODE_CLEAR,  0, 'h00},
    '{NO_WRITE,   3,   3, 63, MODE_SET,    0, 'h10},
    '{NO_WRITE,   5,  12,  1, MODE_INVERT, 0, NO_VALUE},
    '{NO_WRITE,   0, 127,  2, MODE_SET,    1, 'haa},
    '{NO_WRITE,   0, 127,  3, MODE_SET,    1, 'h55},
    '{NO_WRITE,  10,  90,  4, MODE_UNUSED, 1, NO_VALUE},
    '{NO_WRITE,   0, 127,  0, MODE_CLEAR,  1, NO_VALUE},
    '{0,          0, 127,  5, MODE_SET,    1, 'h00},
    '{16,         0, 127,  6, MODE_SET,    1, 'hff},
    '{31,         0, 127,  7, MODE_SET,    1, 'hff},
    '{17,        20,  50,  8, MODE_INVERT, 1, NO_VALUE},
    '{NO_WRITE,   0, 127,  0, MODE_INVERT, 0, NO_VALUE},
    '{NO_WRITE, 127, 127, 63, MODE_SET,    0, 'h01},
    '{NO_WRITE,   0,   7, 10, MODE_SET,    0, 'hff},
    '{NO_WRITE,  15,   8, 10, MODE_INVERT, 0, 'hff},
    '{8,        120,   0, 11, MODE_SET,    1, NO_VALUE},
    '{1,          0, 127, 12, MODE_INVERT, 1, 'h88},
    '{NO_WRITE,   0, 127, 13, MODE_INVERT, 1, 'h00},
    '{NO_WRITE,  64,  64, 14, MODE_SET,    0, 'h80},
    '{NO_WRITE,   0, 127, 63, MODE_CLEAR,  0, 'h00}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [4:0]  cfg_wr_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;

  // Framebuffer model and its pending byte writes
  logic [7:0]  frame_mem [0:1023];
  logic [4:0]  cur_level = LEVEL_RESET;
  byte_write_t expected_bytes [$];

  int fail_count = 0;
  int spans_sent = 0;
  int unused_sent = 0;
  int level_writes = 0;
  int bytes_seen = 0;
  bit rx_calm = 1'b0;
  bit tx_calm = 1'b0;
  bit hold_req = 1'b0;

  span_fill_with_dither uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  initial begin
    for (int a = 0; a < 1024; a++) frame_mem[a] = 8'h00;
  end

  // Apply one span to the framebuffer model and queue the bytes it writes
  function automatic void draw_span(input span_t sp);
    logic [6:0] lo, hi;
    logic [7:0] pat, smask, emask, m, v;
    int         bs, be;
    bit         edge_byte;
    int         addr;
    byte_write_t w;
    if (sp.mode == MODE_UNUSED) return;
    lo = (sp.xe < sp.xs) ? sp.xe : sp.xs;
    hi = (sp.xe < sp.xs) ? sp.xs : sp.xe;
    pat = sp.dith ? DITHER_BYTES[{cur_level, sp.row[1:0]}] : 8'hff;
    smask = 8'hff >> lo[2:0];
    emask = 8'hff << (3'd7 - hi[2:0]);
    bs = int'(lo[6:3]);
    be = int'(hi[6:3]);
    for (int c = bs; c <= be; c++) begin
      addr = sp.row * ROW_BYTES + c;
      v = frame_mem[addr[9:0]];
      edge_byte = (c == bs) || (c == be);
      m = 8'hff;
      if (c == bs) m = m & smask;
      if (c == be) m = m & emask;
      m = m & pat;
      case (sp.mode)
        MODE_SET:   v = edge_byte ? (v | m) : pat;
        MODE_CLEAR: v = edge_byte ? (v & ~m) : ~pat;
        default:    v = v ^ m;
      endcase
      frame_mem[addr[9:0]] = v;
      w.addr = addr[9:0];
      w.value = v;
      w.last = (c == be);
      expected_bytes.push_back(w);
    end
  endfunction

  // Offer one span until accepted; return how many byte writes it queued
  task automatic send_span(input span_t sp, output int n_writes);
    int queued;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, sp.dith, sp.mode, sp.row, sp.xe, sp.xs};
    do @(posedge clk); while (!s_axis_tready);
    queued = expected_bytes.size();
    draw_span(sp);
    n_writes = expected_bytes.size() - queued;
    spans_sent++;
    if (sp.mode == MODE_UNUSED) unused_sent++;
  endtask

  // Drop tvalid for a short random gap now and then
  task automatic maybe_gap();
    if (!tx_calm && $urandom_range(99) < 17) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every queued byte write has come out
  task automatic drain_outputs();
    s_axis_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_level(input logic [4:0] lvl);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= lvl;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (lvl < LEVEL_COUNT) cur_level = lvl;
    level_writes++;
  endtask

  function automatic span_t random_span(input bit full_width);
    span_t sp;
    int    kind, span_len;
    kind = $urandom_range(99);
    if (full_width || kind < 15) begin
      sp.xs = $urandom_range(1) ? 7'd0 : 7'd127;
      sp.xe = ~sp.xs;
    end else if (kind < 45) begin
      sp.xs = 7'($urandom_range(127));
      span_len = $urandom_range(15);
      if ($urandom_range(1))
        sp.xe = (sp.xs + span_len > 127) ? 7'd127 : 7'(sp.xs + span_len);
      else
        sp.xe = (sp.xs < span_len) ? 7'd0 : 7'(sp.xs - span_len);
    end else begin
      sp.xs = 7'($urandom_range(127));
      sp.xe = 7'($urandom_range(127));
    end
    // Keep half the spans on a few rows so bytes get modified many times
    sp.row  = $urandom_range(1) ? 6'($urandom_range(7)) : 6'($urandom_range(63));
    sp.mode = ($urandom_range(99) < 6) ? MODE_UNUSED : span_mode_t'($urandom_range(2));
    sp.dith = 1'($urandom_range(1));
    return sp;
  endfunction

  // Receiver: random stalls, a calm stretch, and one long hold-off on request
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (rx_calm) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 17);
      end
    end
  end

  // Compare each output transaction with the oldest queued byte write
  always @(posedge clk) begin : check_output
    byte_write_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      bytes_seen++;
      if (expected_bytes.size() == 0) begin
        $error("unexpected byte write: byte_address %0d byte_value 0x%02h",
               m_axis_tdata[9:0], m_axis_tdata[17:10]);
        fail_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (m_axis_tdata[9:0] !== want.addr) begin
          $error("byte_address mismatch: expected %0d, got %0d", want.addr, m_axis_tdata[9:0]);
          fail_count++;
        end
        if (m_axis_tdata[17:10] !== want.value) begin
          $error("byte_value mismatch at %0d: expected 0x%02h, got 0x%02h",
                 want.addr, want.value, m_axis_tdata[17:10]);
          fail_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last mismatch at %0d: expected %0b, got %0b", want.addr, want.last,
                 m_axis_tlast);
          fail_count++;
        end
        if (m_axis_tdata[23:18] !== 6'd0) begin
          $error("tdata padding mismatch: expected 0, got 0x%02h", m_axis_tdata[23:18]);
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    span_t sp;
    int    n_writes, drawn, wide_left;
    rst <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed spans
    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (PLAN[i].lvl != NO_WRITE) begin
        drain_outputs();
        set_level(PLAN[i].lvl[4:0]);
      end
      sp.xs   = PLAN[i].xs[6:0];
      sp.xe   = PLAN[i].xe[6:0];
      sp.row  = PLAN[i].row[5:0];
      sp.mode = span_mode_t'(PLAN[i].mode[1:0]);
      sp.dith = PLAN[i].dith[0];
      send_span(sp, n_writes);
      // Pin the byte value where it is plain from the span itself
      if (PLAN[i].val != NO_VALUE)
        for (int j = expected_bytes.size() - n_writes; j < expected_bytes.size(); j++)
          expected_bytes[j].value = PLAN[i].val[7:0];
      maybe_gap();
    end

    // Random phases, one dither setting each
    for (int p = 0; p < 6; p++) begin
      drain_outputs();
      case (p)
        0:       set_level(5'd16);
        1:       set_level(5'd0);
        2:       set_level(5'($urandom_range(16)));
        3:       set_level(5'($urandom_range(17, 31)));
        4:       set_level(5'd4);
        default: set_level(5'd12);
      endcase
      tx_calm = (p == 0);
      rx_calm = (p == 0);
      wide_left = 0;
      drawn = 0;
      while (drawn < PHASE_SPANS) begin
        // Stall the output for a long stretch under a run of full-width spans
        if (p == 1 && drawn == 8) begin
          hold_req = 1'b1;
          wide_left = 12;
        end
        if (p == 2 && drawn == 20) drain_outputs();
        sp = random_span(wide_left > 0);
        if (wide_left > 0) wide_left--;
        send_span(sp, n_writes);
        if (sp.mode != MODE_UNUSED) drawn++;
        maybe_gap();
      end
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;

    drain_outputs();
    $display("Drew %0d spans (%0d with the unused mode) across %0d dither level writes,",
             spans_sent, unused_sent, level_writes);
    $display("with %0d byte writes checked and %0d failures.", bytes_seen, fail_count);
    if (fail_count == 0 && expected_bytes.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("Timed out with %0d byte writes outstanding.", expected_bytes.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
